### hdl/sprl_pkg.sv
package sprl_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_DUP      = 3'd4;

  typedef struct packed {
    logic ins;  // place request item into the list
    logic rem;  // take the hit cell out, close the gap
    logic pop;  // hit means head cell rather than id match
  } ctrl_t;

endpackage

### hdl/sprl_cell.sv
module sprl_cell #(
  parameter int ID_BITS  = 8,
  parameter int TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  sprl_pkg::ctrl_t     ctrl,
  input  logic                first,
  input  logic [ID_BITS-1:0]  req_id,
  input  logic [TAG_BITS-1:0] req_tag,
  input  logic [ID_BITS-1:0]  lo_id,
  input  logic [TAG_BITS-1:0] lo_tag,
  input  logic                lo_valid,
  input  logic                lo_le,
  input  logic                lo_found,
  input  logic [ID_BITS-1:0]  hi_id,
  input  logic [TAG_BITS-1:0] hi_tag,
  input  logic                hi_valid,
  output logic [ID_BITS-1:0]  id,
  output logic [TAG_BITS-1:0] tag,
  output logic                valid,
  output logic                le,
  output logic                match,
  output logic                hit,
  output logic                found
);

  assign le    = valid && (tag <= req_tag);
  assign match = valid && (id == req_id);
  assign hit   = ctrl.pop ? (first && valid) : match;
  assign found = lo_found || hit;

  always_ff @(posedge clk) begin
    if (ctrl.ins && !le) begin
      if (lo_le) begin
        id  <= req_id;
        tag <= req_tag;
      end else begin
        id  <= lo_id;
        tag <= lo_tag;
      end
    end else if (ctrl.rem && found) begin
      id  <= hi_id;
      tag <= hi_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins && !le) begin
      valid <= lo_le ? 1'b1 : lo_valid;
    end else if (ctrl.rem && found) begin
      valid <= hi_valid;
    end
  end

endmodule

### hdl/stable_priority_ready_list.sv
// Stable sorted ready list built as a chain of shifting cells.
// The result strobe (done) is registered and rises in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, the cell chain settles each cycle.
// Reset (rst, synchronous): all cells invalid, count zero, no result pending.
// Results are not held: the receiver takes each one in its strobe cycle.
module stable_priority_ready_list #(
  parameter int ENTRIES  = 16,
  parameter int ID_BITS  = 8,
  parameter int TAG_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   op,
  input  logic [ID_BITS-1:0]           item_id,
  input  logic [TAG_BITS-1:0]          tag,
  output logic                         done,
  output logic [2:0]                   status,
  output logic [ID_BITS-1:0]           out_id,
  output logic [TAG_BITS-1:0]          out_tag,
  output logic [$clog2(ENTRIES+1)-1:0] count
);

  localparam int CW = $clog2(ENTRIES + 1);

  logic [ID_BITS-1:0]  c_id    [ENTRIES];
  logic [TAG_BITS-1:0] c_tag   [ENTRIES];
  logic [ENTRIES-1:0]  c_valid;
  logic [ENTRIES-1:0]  c_le;
  logic [ENTRIES-1:0]  c_match;
  logic [ENTRIES-1:0]  c_hit;
  logic [ENTRIES-1:0]  c_found;

  sprl_pkg::ctrl_t ctrl;
  logic            accept;
  logic            dup;
  logic            full;
  logic            any_hit;
  logic [2:0]      status_next;
  logic [CW-1:0]   count_next;
  logic [ID_BITS-1:0]  hit_id;
  logic [TAG_BITS-1:0] hit_tag;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign dup     = |c_match;
  assign any_hit = |c_hit;
  assign full    = (count == CW'(ENTRIES));

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      logic [ID_BITS-1:0]  lo_id;
      logic [TAG_BITS-1:0] lo_tag;
      logic                lo_valid;
      logic                lo_le;
      logic                lo_found;
      logic [ID_BITS-1:0]  hi_id;
      logic [TAG_BITS-1:0] hi_tag;
      logic                hi_valid;

      if (g == 0) begin : g_head
        assign lo_id    = '0;
        assign lo_tag   = '0;
        assign lo_valid = 1'b0;
        assign lo_le    = 1'b1;
        assign lo_found = 1'b0;
      end else begin : g_body
        assign lo_id    = c_id[g-1];
        assign lo_tag   = c_tag[g-1];
        assign lo_valid = c_valid[g-1];
        assign lo_le    = c_le[g-1];
        assign lo_found = c_found[g-1];
      end

      if (g == ENTRIES - 1) begin : g_tail
        assign hi_id    = '0;
        assign hi_tag   = '0;
        assign hi_valid = 1'b0;
      end else begin : g_inner
        assign hi_id    = c_id[g+1];
        assign hi_tag   = c_tag[g+1];
        assign hi_valid = c_valid[g+1];
      end

      sprl_cell #(
        .ID_BITS  (ID_BITS),
        .TAG_BITS (TAG_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .first    ((g == 0) ? 1'b1 : 1'b0),
        .req_id   (item_id),
        .req_tag  (tag),
        .lo_id    (lo_id),
        .lo_tag   (lo_tag),
        .lo_valid (lo_valid),
        .lo_le    (lo_le),
        .lo_found (lo_found),
        .hi_id    (hi_id),
        .hi_tag   (hi_tag),
        .hi_valid (hi_valid),
        .id       (c_id[g]),
        .tag      (c_tag[g]),
        .valid    (c_valid[g]),
        .le       (c_le[g]),
        .match    (c_match[g]),
        .hit      (c_hit[g]),
        .found    (c_found[g])
      );
    end
  endgenerate

  always_comb begin
    hit_id  = '0;
    hit_tag = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_id  = hit_id  | (c_hit[i] ? c_id[i]  : '0);
      hit_tag = hit_tag | (c_hit[i] ? c_tag[i] : '0);
    end
  end

  always_comb begin
    ctrl        = '0;
    ctrl.pop    = (op == sprl_pkg::OP_POP);
    status_next = sprl_pkg::ST_OK;
    count_next  = count;
    unique case (op)
      sprl_pkg::OP_INSERT: begin
        if (dup) begin
          status_next = sprl_pkg::ST_DUP;
        end else if (full) begin
          status_next = sprl_pkg::ST_FULL;
        end else begin
          ctrl.ins   = accept;
          count_next = count + CW'(1);
        end
      end
      sprl_pkg::OP_POP: begin
        if (!any_hit) begin
          status_next = sprl_pkg::ST_EMPTY;
        end else begin
          ctrl.rem   = accept;
          count_next = count - CW'(1);
        end
      end
      sprl_pkg::OP_REMOVE: begin
        if (!any_hit) begin
          status_next = sprl_pkg::ST_NOTFOUND;
        end else begin
          ctrl.rem   = accept;
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status  <= status_next;
      out_id  <= ctrl.rem ? hit_id  : '0;
      out_tag <= ctrl.rem ? hit_tag : '0;
    end
  end

endmodule

### verif/stable_priority_ready_list_checker.sv
module stable_priority_ready_list_checker #(
  parameter int ENTRIES  = 16,
  parameter int ID_BITS  = 8,
  parameter int TAG_BITS = 16,
  parameter int CNT_BITS = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          op,
  input  logic [ID_BITS-1:0]  item_id,
  input  logic [TAG_BITS-1:0] tag,
  input  logic                done,
  input  logic [2:0]          status,
  input  logic [ID_BITS-1:0]  out_id,
  input  logic [TAG_BITS-1:0] out_tag,
  input  logic [CNT_BITS-1:0] count,
  output int                  mismatch_count,
  output int                  awaited_count
);

  typedef struct packed {
    logic [2:0]          status;
    logic [ID_BITS-1:0]  rid;
    logic [TAG_BITS-1:0] rtag;
    logic [CNT_BITS-1:0] cnt;
  } list_outcome_t;

  logic [ID_BITS-1:0]  list_id  [ENTRIES];
  logic [TAG_BITS-1:0] list_tag [ENTRIES];
  int                  list_len = 0;
  list_outcome_t       awaited_outcomes [$];

  function automatic int locate_id(logic [ID_BITS-1:0] key);
    int hit;
    hit = -1;
    for (int i = list_len - 1; i >= 0; i--) begin
      if (list_id[i] == key) hit = i;
    end
    return hit;
  endfunction

  function automatic void take_out_slot(int pos);
    for (int i = pos; i < list_len - 1; i++) begin
      list_id[i]  = list_id[i+1];
      list_tag[i] = list_tag[i+1];
    end
    list_len--;
  endfunction

  function automatic list_outcome_t apply_list_request(logic [1:0] req_op,
                                                       logic [ID_BITS-1:0] req_id,
                                                       logic [TAG_BITS-1:0] req_tag);
    list_outcome_t res;
    int pos;
    res = '0;
    res.status = sprl_pkg::ST_OK;
    case (req_op)
      sprl_pkg::OP_INSERT: begin
        if (locate_id(req_id) >= 0) begin
          res.status = sprl_pkg::ST_DUP;
        end else if (list_len >= ENTRIES) begin
          res.status = sprl_pkg::ST_FULL;
        end else begin
          // stable: goes after every entry with tag <= its own
          pos = 0;
          for (int i = 0; i < list_len; i++) begin
            if (list_tag[i] <= req_tag) pos = i + 1;
          end
          for (int i = list_len; i > pos; i--) begin
            list_id[i]  = list_id[i-1];
            list_tag[i] = list_tag[i-1];
          end
          list_id[pos]  = req_id;
          list_tag[pos] = req_tag;
          list_len++;
        end
      end
      sprl_pkg::OP_POP: begin
        if (list_len == 0) begin
          res.status = sprl_pkg::ST_EMPTY;
        end else begin
          res.rid  = list_id[0];
          res.rtag = list_tag[0];
          take_out_slot(0);
        end
      end
      sprl_pkg::OP_REMOVE: begin
        pos = locate_id(req_id);
        if (pos < 0) begin
          res.status = sprl_pkg::ST_NOTFOUND;
        end else begin
          res.rid  = list_id[pos];
          res.rtag = list_tag[pos];
          take_out_slot(pos);
        end
      end
      default: ;
    endcase
    res.cnt = CNT_BITS'(list_len);
    return res;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    list_outcome_t want;
    if (rst) begin
      list_len = 0;
      awaited_outcomes.delete();
    end else begin
      if (done) begin
        if (awaited_outcomes.size() == 0) begin
          $display({"%0t: unexpected result, expected none, ",
                    "actual status %0d id %0d tag %0d count %0d"},
                   $time, status, out_id, out_tag, count);
          mismatch_count++;
        end else begin
          want = awaited_outcomes.pop_front();
          report_field("status", 32'(want.status), 32'(status));
          report_field("out_id", 32'(want.rid), 32'(out_id));
          report_field("out_tag", 32'(want.rtag), 32'(out_tag));
          report_field("count", 32'(want.cnt), 32'(count));
        end
      end
      if (start && !busy) begin
        awaited_outcomes.push_back(apply_list_request(op, item_id, tag));
      end
    end
    awaited_count = awaited_outcomes.size();
  end

endmodule

### verif/stable_priority_ready_list_tb.sv
module stable_priority_ready_list_tb;

  localparam int ENTRIES      = 16;
  localparam int ID_BITS      = 8;
  localparam int TAG_BITS     = 16;
  localparam int CNT_BITS     = $clog2(ENTRIES + 1);
  localparam int RANDOM_ITEMS = 1925;
  localparam int POOL_SIZE    = 24;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [1:0]          op = sprl_pkg::OP_INSERT;
  logic [ID_BITS-1:0]  item_id = '0;
  logic [TAG_BITS-1:0] tag = '0;
  logic                busy;
  logic                done;
  logic [2:0]          status;
  logic [ID_BITS-1:0]  out_id;
  logic [TAG_BITS-1:0] out_tag;
  logic [CNT_BITS-1:0] count;
  int                  mismatch_count;
  int                  awaited_count;

  int                  cycles = 0;
  int                  burst_left = 0;
  logic [ID_BITS-1:0]  id_pool [POOL_SIZE];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  stable_priority_ready_list #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .op     (op),
    .item_id(item_id),
    .tag    (tag),
    .done   (done),
    .status (status),
    .out_id (out_id),
    .out_tag(out_tag),
    .count  (count)
  );

  stable_priority_ready_list_checker #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .item_id       (item_id),
    .tag           (tag),
    .done          (done),
    .status        (status),
    .out_id        (out_id),
    .out_tag       (out_tag),
    .count         (count),
    .mismatch_count(mismatch_count),
    .awaited_count (awaited_count)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic issue(input logic [1:0] req_op, input logic [ID_BITS-1:0] req_id,
                       input logic [TAG_BITS-1:0] req_tag);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start   <= 1'b0;
        op      <= 2'($urandom);
        item_id <= ID_BITS'($urandom);
        tag     <= TAG_BITS'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    op      <= req_op;
    item_id <= req_id;
    tag     <= req_tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int ins_weight;
    int r;
    int rest;
    int span;
    logic [1:0] rop;
    logic [ID_BITS-1:0] rid;
    logic [TAG_BITS-1:0] rtag;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: error cases, tie ordering, tail append, fill to full
    issue(sprl_pkg::OP_POP, 8'd0, 16'd0);
    issue(sprl_pkg::OP_REMOVE, 8'd77, 16'hFFFF);
    issue(sprl_pkg::OP_INSERT, 8'd0, 16'hFFFF);
    issue(sprl_pkg::OP_INSERT, 8'd255, 16'd0);
    issue(sprl_pkg::OP_INSERT, 8'd0, 16'd5);
    issue(sprl_pkg::OP_INSERT, 8'd1, 16'hFFFF);
    issue(sprl_pkg::OP_INSERT, 8'd2, 16'd0);
    issue(sprl_pkg::OP_REMOVE, 8'd1, 16'd0);
    issue(sprl_pkg::OP_POP, 8'd0, 16'd0);
    for (int k = 0; k < 14; k++) begin
      issue(sprl_pkg::OP_INSERT, ID_BITS'(16 + k),
            (k % 3 == 0) ? 16'hFFFF : TAG_BITS'($urandom_range(0, 2)));
    end
    issue(sprl_pkg::OP_INSERT, 8'd200, 16'd1);
    issue(sprl_pkg::OP_INSERT, 8'd2, 16'd1);
    issue(OP_UNUSED, 8'hFF, 16'hFFFF);

    // random: phases swing the list between empty and full
    ins_weight = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 256 == 0) begin
        foreach (id_pool[p]) id_pool[p] = ID_BITS'($urandom);
      end
      if (n % 64 == 0) begin
        case ($urandom_range(3))
          0: ins_weight = 20;
          1: ins_weight = 45;
          2: ins_weight = 60;
          default: ins_weight = 85;
        endcase
      end
      r    = $urandom_range(99);
      span = 100 - ins_weight;
      rest = r - ins_weight;
      if (r < ins_weight) rop = sprl_pkg::OP_INSERT;
      else if (rest < span / 2) rop = sprl_pkg::OP_POP;
      else if (rest < span * 9 / 10) rop = sprl_pkg::OP_REMOVE;
      else rop = OP_UNUSED;
      rid = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE - 1)]
                                      : ID_BITS'($urandom);
      case ($urandom_range(3))
        0: rtag = TAG_BITS'($urandom_range(0, 3));
        1: rtag = TAG_BITS'($urandom_range(65532, 65535));
        default: rtag = TAG_BITS'($urandom);
      endcase
      issue(rop, rid, rtag);
    end

    start <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/sprl_pkg.sv
hdl/sprl_cell.sv
hdl/stable_priority_ready_list.sv
verif/stable_priority_ready_list_checker.sv
verif/stable_priority_ready_list_tb.sv
